>>> sv/first_fit_block_allocator_defines.svh
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define FFBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ffba check failed");
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba check failed");
`else
`define FFBA_ASSERT(label, clk, rst_n, prop)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
package ffba_pkg;

    localparam int HEADER_BYTES_DEF = 12;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int OFFSET_BITS      = 16;

    localparam logic [16:0] POOL_RESET = 17'd4096;
    localparam logic [16:0] POOL_MIN   = 17'd16;
    localparam logic [16:0] POOL_MAX   = 17'd65536;

    localparam int          ADDR_W    = 2;
    localparam logic [1:0]  ADDR_POOL = 2'd0;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;
    localparam logic [1:0] OP_RSVD    = 2'd3;

    localparam logic [1:0] ST_GIVEN   = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] pay;
        logic                   free;
    } t_ent;

endpackage

>>> sv/ffba_ram.sv
// block table memory, one write and one registered read port
module ffba_ram #(
    parameter int  DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [IW-1:0]  i_waddr,
    input  ffba_pkg::t_ent i_wdata,
    input  logic [IW-1:0]  i_raddr,
    output ffba_pkg::t_ent o_rdata
);
    import ffba_pkg::*;

    t_ent r_mem [DEPTH];
    t_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/first_fit_block_allocator.sv
// first-fit block allocator: table walk, split, merge and reallocate sequencer
//
//  channel   direction  handshake            payload
//  in        in         i_valid / o_ready    opcode, size_bytes, old_offset, has_old
//  out       out        o_valid / i_ready    status, offsets, copy info, bytes_in_use
//  cfg       in         psel/penable/pwrite  pool_bytes at address 0
//
// one item at a time; a new item is taken only in idle, after the last result is loaded
// allocate walks the table and may shift entries up to split; reallocate with a move also frees the old block
// reset and a pool write clear the table; entry 0 is then rewritten in the init state as one free block
// the result waits in an output register; a stalled output holds the next item at the end
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [15:0]                i_size_bytes,
    input  logic [15:0]                i_old_offset,
    input  logic                       i_has_old,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [15:0]                o_payload_offset,
    output logic                       o_must_copy,
    output logic [15:0]                o_copy_from,
    output logic [15:0]                o_copy_bytes,
    output logic [16:0]                o_bytes_in_use,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ffba_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ffba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);
    localparam logic [15:0]   HDR16 = 16'(HEADER_BYTES);
    localparam logic [16:0]   HDR17 = 17'(HEADER_BYTES);
    localparam logic [17:0]   HDR18 = 18'(HEADER_BYTES);

    typedef enum logic [12:0] {
        S_INIT = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_SCAN = 13'b0000000000100,
        S_HIT  = 13'b0000000001000,
        S_INS  = 13'b0000000010000,
        S_WRI  = 13'b0000000100000,
        S_SM   = 13'b0000001000000,
        S_F0   = 13'b0000010000000,
        S_F1   = 13'b0000100000000,
        S_F2   = 13'b0001000000000,
        S_F3   = 13'b0010000000000,
        S_REM  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    typedef enum logic [4:0] {
        PH_ALLOC = 5'b00001,
        PH_GROW  = 5'b00010,
        PH_FREE  = 5'b00100,
        PH_GFREE = 5'b01000,
        PH_REAL  = 5'b10000
    } t_phase;

    function automatic logic [16:0] sat_sub(input logic [16:0] a, input logic [16:0] b);
        sat_sub = (a > b) ? (a - b) : 17'd0;
    endfunction

    t_state        r_state, n_state, r_ret, n_ret;
    t_phase        r_phase, n_phase;
    logic [16:0]   r_pool, n_pool;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [16:0]   r_used, n_used;
    logic [16:0]   r_req, n_req;
    logic [15:0]   r_old, n_old;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pk, n_pk;
    logic [IW-1:0] r_idx, n_idx;
    t_ent          r_ent, n_ent;
    t_ent          r_new, n_new;
    logic [1:0]    r_st, n_st;
    logic [15:0]   r_poff, n_poff;
    logic          r_mc, n_mc;
    logic [15:0]   r_cbytes, n_cbytes;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_o_status;
    logic [15:0]   r_o_poff, r_o_cfrom, r_o_cbytes;
    logic          r_o_mc;
    logic [16:0]   r_o_used;
    logic          w_load;

    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    t_ent          w_wdata, w_rd, w_split_ent;
    logic          w_issue, w_match, w_split4, w_split8, w_cfg_we;
    logic [17:0]   w_pay18;
    logic [CW-1:0] w_idx_c;
    logic [16:0]   w_clamp;

    ffba_ram #(.DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_cfg_we = psel && penable && pwrite && (paddr == ADDR_POOL);
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_POOL) ? 32'(r_pool) : 32'd0;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        w_clamp = pwdata[16:0];
        if (w_clamp > POOL_MAX) begin
            w_clamp = POOL_MAX;
        end
        if (w_clamp < POOL_MIN) begin
            w_clamp = POOL_MIN;
        end
        if (w_clamp < HDR17) begin
            w_clamp = HDR17;
        end
    end

    always_comb begin
        w_idx_c  = CW'(r_idx);
        w_pay18  = {2'b00, r_ent.pay};
        w_split4 = (w_pay18 >= ({1'b0, r_req} + HDR18 + 18'd4)) && (r_cnt < MAXC);
        w_split8 = (w_pay18 >= ({1'b0, r_req} + HDR18 + 18'd8)) && (r_cnt < MAXC);
        w_split_ent.start = 16'(r_ent.start + HDR16 + r_req[15:0]);
        w_split_ent.pay   = 16'(r_ent.pay - r_req[15:0] - HDR16);
        w_split_ent.free  = 1'b1;
        if (r_phase == PH_ALLOC || r_phase == PH_GROW) begin
            w_match = w_rd.free && ({1'b0, w_rd.pay} >= r_req);
        end else begin
            w_match = !w_rd.free && (({1'b0, w_rd.start} + HDR17) == {1'b0, r_old});
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_phase  = r_phase;
        n_pool   = r_pool;
        n_cnt    = r_cnt;
        n_used   = r_used;
        n_req    = r_req;
        n_old    = r_old;
        n_k      = r_k;
        n_pos    = r_pos;
        n_pv     = 1'b0;
        n_pk     = r_pk;
        n_idx    = r_idx;
        n_ent    = r_ent;
        n_new    = r_new;
        n_st     = r_st;
        n_poff   = r_poff;
        n_mc     = r_mc;
        n_cbytes = r_cbytes;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = r_ent;
        w_raddr  = '0;
        w_issue  = 1'b0;
        w_load   = 1'b0;

        case (r_state)
            S_INIT: begin
                w_we          = 1'b1;
                w_waddr       = '0;
                w_wdata.start = '0;
                w_wdata.pay   = 16'(r_pool - HDR17);
                w_wdata.free  = 1'b1;
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = ({1'b0, i_size_bytes} + 17'd3) & ~17'd3;
                    n_old    = i_old_offset;
                    n_st     = ST_NONE;
                    n_poff   = '0;
                    n_mc     = 1'b0;
                    n_cbytes = '0;
                    n_k      = '0;
                    n_state  = S_OUT;
                    case (i_opcode)
                        OP_ALLOC: begin
                            if (i_size_bytes != 16'd0) begin
                                n_phase = PH_ALLOC;
                                n_state = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (i_has_old) begin
                                n_phase = PH_FREE;
                                n_state = S_SCAN;
                            end
                        end
                        OP_REALLOC: begin
                            if (i_size_bytes == 16'd0) begin
                                if (i_has_old) begin
                                    n_phase = PH_FREE;
                                    n_state = S_SCAN;
                                end
                            end else if (!i_has_old) begin
                                n_phase = PH_ALLOC;
                                n_state = S_SCAN;
                            end else begin
                                n_phase = PH_REAL;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_issue = (r_k < r_cnt);
                w_raddr = r_k[IW-1:0];
                n_k     = w_issue ? CW'(r_k + 1'b1) : r_k;
                n_pv    = w_issue;
                n_pk    = w_raddr;
                if (r_pv && w_match) begin
                    n_idx   = r_pk;
                    n_ent   = w_rd;
                    n_pv    = 1'b0;
                    n_state = S_HIT;
                end else if (!r_pv && !w_issue) begin
                    n_state = S_OUT;
                    case (r_phase)
                        PH_ALLOC, PH_GROW: n_st = ST_NOFIT;
                        PH_FREE, PH_REAL:  n_st = ST_UNKNOWN;
                        default:           n_st = r_st;
                    endcase
                end
            end
            S_HIT: begin
                case (r_phase)
                    PH_ALLOC, PH_GROW: begin
                        n_st   = ST_GIVEN;
                        n_poff = 16'(r_ent.start + HDR16);
                        if (r_phase == PH_GROW) begin
                            n_mc = 1'b1;
                        end
                        n_ent.free = 1'b0;
                        if (w_split4) begin
                            n_new     = w_split_ent;
                            n_ent.pay = r_req[15:0];
                            n_used    = 17'(r_used + {1'b0, r_req[15:0]} + HDR17);
                            n_pos     = CW'(w_idx_c + 1'b1);
                            n_k       = r_cnt;
                            n_state   = S_INS;
                        end else begin
                            w_we       = 1'b1;
                            w_waddr    = r_idx;
                            w_wdata    = r_ent;
                            w_wdata.free = 1'b0;
                            n_used     = 17'(r_used + {1'b0, r_ent.pay} + HDR17);
                            if (r_phase == PH_GROW) begin
                                n_phase = PH_GFREE;
                                n_k     = '0;
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                    end
                    PH_FREE: begin
                        n_st    = ST_NONE;
                        n_state = S_F0;
                    end
                    PH_GFREE: begin
                        n_state = S_F0;
                    end
                    PH_REAL: begin
                        if (r_req <= {1'b0, r_ent.pay}) begin
                            n_st    = ST_GIVEN;
                            n_poff  = r_old;
                            n_state = S_OUT;
                            if (w_split8) begin
                                n_new     = w_split_ent;
                                n_ent.pay = r_req[15:0];
                                n_used    = sat_sub(r_used, {1'b0, r_ent.pay} - r_req);
                                n_pos     = CW'(w_idx_c + 1'b1);
                                n_k       = r_cnt;
                                n_state   = S_INS;
                            end
                        end else begin
                            n_cbytes = r_ent.pay;
                            n_phase  = PH_GROW;
                            n_k      = '0;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_INS: begin
                w_issue = (r_k > r_pos);
                w_raddr = IW'(r_k - 1'b1);
                n_k     = w_issue ? CW'(r_k - 1'b1) : r_k;
                n_pv    = w_issue;
                n_pk    = w_raddr;
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = IW'(r_pk + 1'b1);
                    w_wdata = w_rd;
                end else if (!w_issue) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[IW-1:0];
                    w_wdata = r_new;
                    n_cnt   = CW'(r_cnt + 1'b1);
                    n_state = S_WRI;
                end
            end
            S_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_ent;
                w_raddr = IW'(w_idx_c + CW'(2));
                case (r_phase)
                    PH_GROW: begin
                        n_phase = PH_GFREE;
                        n_k     = '0;
                        n_state = S_SCAN;
                    end
                    PH_REAL: n_state = S_SM;
                    default: n_state = S_OUT;
                endcase
            end
            S_SM: begin
                n_state = S_OUT;
                if ((CW'(w_idx_c + CW'(2)) < r_cnt) && w_rd.free) begin
                    w_we          = 1'b1;
                    w_waddr       = IW'(w_idx_c + 1'b1);
                    w_wdata.start = r_new.start;
                    w_wdata.pay   = 16'(r_new.pay + HDR16 + w_rd.pay);
                    w_wdata.free  = 1'b1;
                    n_pos         = CW'(w_idx_c + CW'(2));
                    n_k           = CW'(w_idx_c + CW'(3));
                    n_ret         = S_OUT;
                    n_state       = S_REM;
                end
            end
            S_F0: begin
                n_used     = sat_sub(r_used, 17'({1'b0, r_ent.pay} + HDR17));
                n_ent.free = 1'b1;
                w_raddr    = IW'(w_idx_c + 1'b1);
                n_state    = S_F1;
            end
            S_F1: begin
                n_state = S_F2;
                if ((CW'(w_idx_c + 1'b1) < r_cnt) && w_rd.free) begin
                    n_ent.pay = 16'(r_ent.pay + HDR16 + w_rd.pay);
                    n_pos     = CW'(w_idx_c + 1'b1);
                    n_k       = CW'(w_idx_c + CW'(2));
                    n_ret     = S_F2;
                    n_state   = S_REM;
                end
            end
            S_F2: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_ent;
                w_raddr = IW'(r_idx - 1'b1);
                n_state = (r_idx != '0) ? S_F3 : S_OUT;
            end
            S_F3: begin
                n_state = S_OUT;
                if (w_rd.free) begin
                    w_we          = 1'b1;
                    w_waddr       = IW'(r_idx - 1'b1);
                    w_wdata.start = w_rd.start;
                    w_wdata.pay   = 16'(w_rd.pay + HDR16 + r_ent.pay);
                    w_wdata.free  = 1'b1;
                    n_pos         = w_idx_c;
                    n_k           = CW'(w_idx_c + 1'b1);
                    n_ret         = S_OUT;
                    n_state       = S_REM;
                end
            end
            S_REM: begin
                w_issue = (r_k < r_cnt);
                w_raddr = r_k[IW-1:0];
                n_k     = w_issue ? CW'(r_k + 1'b1) : r_k;
                n_pv    = w_issue;
                n_pk    = w_raddr;
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = IW'(r_pk - 1'b1);
                    w_wdata = w_rd;
                end else if (!w_issue) begin
                    n_cnt   = CW'(r_cnt - 1'b1);
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (w_cfg_we) begin
            n_pool  = w_clamp;
            n_cnt   = CW'(1);
            n_used  = '0;
            n_state = S_INIT;
        end

        n_ovalid = w_load || (r_ovalid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_pool   <= POOL_RESET;
            r_cnt    <= CW'(1);
            r_used   <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pool   <= n_pool;
            r_cnt    <= n_cnt;
            r_used   <= n_used;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_phase  <= n_phase;
        r_req    <= n_req;
        r_old    <= n_old;
        r_k      <= n_k;
        r_pos    <= n_pos;
        r_pk     <= n_pk;
        r_idx    <= n_idx;
        r_ent    <= n_ent;
        r_new    <= n_new;
        r_st     <= n_st;
        r_poff   <= n_poff;
        r_mc     <= n_mc;
        r_cbytes <= n_cbytes;
        if (w_load) begin
            r_o_status <= r_st;
            r_o_poff   <= r_poff;
            r_o_mc     <= r_mc;
            r_o_cfrom  <= r_mc ? r_old : 16'd0;
            r_o_cbytes <= r_mc ? r_cbytes : 16'd0;
            r_o_used   <= r_used;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_o_status;
    assign o_payload_offset = r_o_poff;
    assign o_must_copy      = r_o_mc;
    assign o_copy_from      = r_o_cfrom;
    assign o_copy_bytes     = r_o_cbytes;
    assign o_bytes_in_use   = r_o_used;

    `FFBA_ASSERT(a_cnt_range, i_clk, i_rst_n, (r_cnt != '0) && (r_cnt <= MAXC))
    `FFBA_ASSERT(a_used_le_pool, i_clk, i_rst_n, r_used <= r_pool)
    `FFBA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule
